@@ sv/bencode_stream_validator_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the bencode stream validator
// Shared property forms with a synchronous active-low reset as the disable.
// ----------------------------------------------------------------------------
`ifndef BENCODE_STREAM_VALIDATOR_CORE_ASSERT_SVH
`define BENCODE_STREAM_VALIDATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSV_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bencode validator check failed");

// The consequent must hold in the cycle after the antecedent.
`define BSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bencode validator check failed");

`endif

@@ sv/bsv_pkg.sv @@
// ----------------------------------------------------------------------------
// bsv_pkg
// Types and constants shared by the bencode stream validator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bsv_pkg;

  // Per-byte status codes.
  localparam logic [1:0] ST_INCOMPLETE = 2'd0;
  localparam logic [1:0] ST_DONE       = 2'd1;
  localparam logic [1:0] ST_ERROR      = 2'd2;

  // Kind of the top-level value.
  typedef enum logic [1:0] {
    KIND_INT  = 2'd0,
    KIND_STR  = 2'd1,
    KIND_LIST = 2'd2,
    KIND_DICT = 2'd3
  } kind_t;

  // What an open container expects next.
  typedef enum logic [1:0] {
    SLOT_LIST     = 2'd0,
    SLOT_DICT_KEY = 2'd1,
    SLOT_DICT_VAL = 2'd2
  } slot_t;

  // Framing characters.
  localparam logic [7:0] CH_INT   = 8'h69; // 'i'
  localparam logic [7:0] CH_LIST  = 8'h6C; // 'l'
  localparam logic [7:0] CH_DICT  = 8'h64; // 'd'
  localparam logic [7:0] CH_END   = 8'h65; // 'e'
  localparam logic [7:0] CH_COLON = 8'h3A; // ':'
  localparam logic [7:0] CH_MINUS = 8'h2D; // '-'
  localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
  localparam logic [7:0] CH_NINE  = 8'h39; // '9'

  // One result as produced by the parse engine.
  typedef struct packed {
    logic [1:0]         status;
    kind_t              value_type;
    logic signed [63:0] int_value;
    logic [31:0]        str_length;
    logic [31:0]        raw_length;
  } result_t;

endpackage

`default_nettype wire

@@ sv/bsv_engine.sv @@
// ----------------------------------------------------------------------------
// bsv_engine
// Holds the running parse state and works out the status of each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bsv_engine #(
  parameter int MAX_NEST = 16,
  parameter int LEN_BITS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step_en,
  input  wire logic [7:0]      data_byte,
  input  wire logic            last,
  output bsv_pkg::result_t     res
);

  localparam int ACC_W = (LEN_BITS > 63) ? LEN_BITS : 63;
  localparam int PRD_W = ACC_W + 4;
  localparam int LVL_W = $clog2(MAX_NEST + 2);
  localparam int IDX_W = $clog2(MAX_NEST + 1);
  localparam logic [PRD_W-1:0] IntMax = {{(PRD_W - 63){1'b0}}, {63{1'b1}}};
  localparam logic [PRD_W-1:0] LenMax = {{(PRD_W - LEN_BITS){1'b0}}, {LEN_BITS{1'b1}}};
  localparam logic [LEN_BITS-1:0] CntMax = {LEN_BITS{1'b1}};

  typedef enum logic [2:0] {
    MODE_VALUE,
    MODE_INT_SIGN,
    MODE_INT_DIG,
    MODE_STR_LEN,
    MODE_PAYLOAD
  } mode_t;

  mode_t                mode_r, mode_nxt;
  logic [LVL_W-1:0]     level_r, level_nxt;
  bsv_pkg::slot_t       top_slot_r, top_slot_nxt;
  bsv_pkg::slot_t       parent_r [MAX_NEST+1];
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic                 neg_r, neg_nxt;
  logic                 seen_r, seen_nxt;
  logic [LEN_BITS-1:0]  rem_r, rem_nxt;
  logic [LEN_BITS-1:0]  cnt_r, cnt_nxt;
  bsv_pkg::kind_t       kind_r, kind_nxt;

  logic                 is_dig;
  logic [3:0]           dval;
  logic [PRD_W-1:0]     mul10;
  logic                 err;
  logic                 do_done;
  logic                 push_we;
  logic [IDX_W-1:0]     push_idx;
  logic [IDX_W-1:0]     pop_idx;
  bsv_pkg::slot_t       pop_slot;
  logic [63:0]          mag;
  logic [63:0]          cnt_ext;
  logic [LVL_W-1:0]     level_dec;
  logic                 in_key;

  // Digit decode and the next decimal accumulation step.
  assign is_dig    = (data_byte >= bsv_pkg::CH_ZERO) && (data_byte <= bsv_pkg::CH_NINE);
  assign dval      = data_byte[3:0];
  assign mul10     = {acc_r, 3'b000} + {2'b00, acc_r, 1'b0} + PRD_W'(dval);
  assign level_dec = level_r - LVL_W'(1);
  assign push_idx  = level_r[IDX_W-1:0];
  assign pop_idx   = level_dec[IDX_W-1:0];
  assign pop_slot  = parent_r[pop_idx];
  assign in_key    = (level_r != '0) && (top_slot_r == bsv_pkg::SLOT_DICT_KEY);

  // Next-state and result logic for one byte.
  always_comb begin
    mode_nxt     = mode_r;
    level_nxt    = level_r;
    top_slot_nxt = top_slot_r;
    acc_nxt      = acc_r;
    neg_nxt      = neg_r;
    seen_nxt     = seen_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;
    kind_nxt     = kind_r;
    err          = 1'b0;
    do_done      = 1'b0;
    push_we      = 1'b0;
    res          = '0;
    mag          = '0;
    cnt_ext      = '0;

    if (cnt_r == CntMax) begin
      // The byte counter has no room left.
      err = 1'b1;
    end else begin
      cnt_nxt = cnt_r + LEN_BITS'(1);
      case (mode_r)
        MODE_VALUE: begin
          if ((level_r != '0) && (top_slot_r != bsv_pkg::SLOT_DICT_VAL) &&
              (data_byte == bsv_pkg::CH_END)) begin
            // Close the innermost container.
            level_nxt = level_dec;
            if (level_r > LVL_W'(1)) begin
              top_slot_nxt = pop_slot;
            end
            do_done = 1'b1;
          end else if (in_key && !is_dig) begin
            err = 1'b1;
          end else if (!in_key && (level_r > LVL_W'(MAX_NEST))) begin
            err = 1'b1;
          end else if (data_byte == bsv_pkg::CH_INT) begin
            if (level_r == '0) begin
              kind_nxt = bsv_pkg::KIND_INT;
            end
            acc_nxt  = '0;
            neg_nxt  = 1'b0;
            seen_nxt = 1'b0;
            mode_nxt = MODE_INT_SIGN;
          end else if (is_dig) begin
            if (level_r == '0) begin
              kind_nxt = bsv_pkg::KIND_STR;
            end
            acc_nxt  = ACC_W'(dval);
            mode_nxt = MODE_STR_LEN;
          end else if ((data_byte == bsv_pkg::CH_LIST) ||
                       (data_byte == bsv_pkg::CH_DICT)) begin
            // Open a container and save the enclosing one's slot.
            if (level_r == '0) begin
              kind_nxt = (data_byte == bsv_pkg::CH_LIST) ? bsv_pkg::KIND_LIST
                                                         : bsv_pkg::KIND_DICT;
            end
            push_we      = 1'b1;
            top_slot_nxt = (data_byte == bsv_pkg::CH_LIST) ? bsv_pkg::SLOT_LIST
                                                           : bsv_pkg::SLOT_DICT_KEY;
            level_nxt    = level_r + LVL_W'(1);
          end else begin
            err = 1'b1;
          end
        end
        MODE_INT_SIGN, MODE_INT_DIG: begin
          mode_nxt = MODE_INT_DIG;
          if ((mode_r == MODE_INT_SIGN) && (data_byte == bsv_pkg::CH_MINUS)) begin
            neg_nxt = 1'b1;
          end else if (is_dig) begin
            if (mul10 > IntMax) begin
              err = 1'b1;
            end else begin
              acc_nxt  = mul10[ACC_W-1:0];
              seen_nxt = 1'b1;
            end
          end else if ((data_byte == bsv_pkg::CH_END) && seen_r) begin
            do_done = 1'b1;
          end else begin
            err = 1'b1;
          end
        end
        MODE_STR_LEN: begin
          if (is_dig) begin
            if (mul10 > LenMax) begin
              err = 1'b1;
            end else begin
              acc_nxt = mul10[ACC_W-1:0];
            end
          end else if (data_byte == bsv_pkg::CH_COLON) begin
            rem_nxt = acc_r[LEN_BITS-1:0];
            if (acc_r == '0) begin
              do_done = 1'b1;
            end else begin
              mode_nxt = MODE_PAYLOAD;
            end
          end else begin
            err = 1'b1;
          end
        end
        MODE_PAYLOAD: begin
          if (rem_r != '0) begin
            rem_nxt = rem_r - LEN_BITS'(1);
          end
          if (rem_nxt == '0) begin
            do_done = 1'b1;
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase
    end

    // A value or key has ended: finish at top level, else flip the dictionary slot.
    if (do_done) begin
      mode_nxt = MODE_VALUE;
      if (level_nxt == '0) begin
        res.status = bsv_pkg::ST_DONE;
      end else if (top_slot_nxt == bsv_pkg::SLOT_DICT_KEY) begin
        top_slot_nxt = bsv_pkg::SLOT_DICT_VAL;
      end else if (top_slot_nxt == bsv_pkg::SLOT_DICT_VAL) begin
        top_slot_nxt = bsv_pkg::SLOT_DICT_KEY;
      end
    end

    if (err) begin
      res.status = bsv_pkg::ST_ERROR;
    end else if ((res.status == bsv_pkg::ST_INCOMPLETE) && last) begin
      // The buffer ended before the value did.
      res.status = bsv_pkg::ST_ERROR;
    end

    // Fill the result fields for a completed value.
    if (res.status == bsv_pkg::ST_DONE) begin
      res.value_type = kind_nxt;
      mag            = 64'(acc_nxt[62:0]);
      if (kind_nxt == bsv_pkg::KIND_INT) begin
        res.int_value = neg_nxt ? -mag : mag;
      end
      if (kind_nxt == bsv_pkg::KIND_STR) begin
        res.str_length = acc_nxt[31:0];
      end
      cnt_ext        = 64'(cnt_nxt);
      res.raw_length = cnt_ext[31:0];
    end

    // Any finished or failed value starts the parse afresh.
    if (res.status != bsv_pkg::ST_INCOMPLETE) begin
      mode_nxt     = MODE_VALUE;
      level_nxt    = '0;
      top_slot_nxt = bsv_pkg::SLOT_LIST;
      acc_nxt      = '0;
      neg_nxt      = 1'b0;
      seen_nxt     = 1'b0;
      rem_nxt      = '0;
      cnt_nxt      = '0;
      kind_nxt     = bsv_pkg::KIND_INT;
      push_we      = 1'b0;
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_VALUE;
      level_r    <= '0;
      top_slot_r <= bsv_pkg::SLOT_LIST;
      acc_r      <= '0;
      neg_r      <= 1'b0;
      seen_r     <= 1'b0;
      rem_r      <= '0;
      cnt_r      <= '0;
      kind_r     <= bsv_pkg::KIND_INT;
    end else if (step_en) begin
      mode_r     <= mode_nxt;
      level_r    <= level_nxt;
      top_slot_r <= top_slot_nxt;
      acc_r      <= acc_nxt;
      neg_r      <= neg_nxt;
      seen_r     <= seen_nxt;
      rem_r      <= rem_nxt;
      cnt_r      <= cnt_nxt;
      kind_r     <= kind_nxt;
    end
  end

  // Saved slots of enclosing containers; each entry is written on open before it is read.
  always_ff @(posedge clk) begin
    if (step_en && push_we) begin
      parent_r[push_idx] <= top_slot_r;
    end
  end

endmodule

`default_nettype wire

@@ sv/bencode_stream_validator_core.sv @@
// ----------------------------------------------------------------------------
// bencode_stream_validator_core
// Byte-stream checker for one complete bencode value at a time.
//
// The slave channel takes one byte per request in in_tdata[7:0], with in_tlast
// marking the final byte of the buffer. The master channel returns one result
// request for every byte: status and top-level type in out_tuser, and the
// integer value, string length and raw length in out_tdata.
// out_tvalid rises in the cycle after a byte is accepted, and a new byte can be
// taken every cycle while the receiver keeps up; the running parse state is
// updated by a single layer of logic per byte, the longest path being the
// multiply-by-ten compare of the 63-bit accumulator.
// When the receiver stalls, the result stays in the output register and
// in_tready falls until that result is taken, so nothing is lost.
// After a completion or an error the next byte begins a new value.
// Reset empties the output register and returns the parser to the start of a
// value with no container open.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bencode_stream_validator_core_assert.svh"

module bencode_stream_validator_core #(
  parameter int MAX_NEST = 16,
  parameter int LEN_BITS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] data_byte
  input  wire logic         in_tlast,   // last
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  output      logic [127:0] out_tdata,  // [63:0] int_value, [95:64] str_length,
                                        // [127:96] raw_length
  output      logic [3:0]   out_tuser   // [1:0] status, [3:2] value_type
);

  logic             in_acc;
  bsv_pkg::result_t res;
  logic             out_valid_r;
  logic [127:0]     out_tdata_r;
  logic [3:0]       out_tuser_r;

  // Accept while the output register is empty or being emptied.
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  bsv_engine #(
    .MAX_NEST (MAX_NEST),
    .LEN_BITS (LEN_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_acc),
    .data_byte (in_tdata),
    .last      (in_tlast),
    .res       (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_tdata_r <= {res.raw_length, res.str_length, res.int_value};
      out_tuser_r <= {res.value_type, res.status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Every accepted byte yields a result in the next cycle.
  `BSV_ASSERT_NEXT(a_result_follows, clk, rst_n, in_acc, out_tvalid)
  // An empty output register never blocks the input.
  `BSV_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready)
  // Only a completed value carries a type and payload fields.
  `BSV_ASSERT_SAME(a_fields_zero, clk, rst_n, out_tvalid && (out_tuser[1:0] != bsv_pkg::ST_DONE), (out_tdata == '0) && (out_tuser[3:2] == 2'b00))

endmodule

`default_nettype wire
